FILE: rtl/core/stereo_fir_filter_unit_assert.svh
// Assertion macros shared by the stereo FIR filter RTL.
`ifndef STEREO_FIR_FILTER_UNIT_ASSERT_SVH
`define STEREO_FIR_FILTER_UNIT_ASSERT_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define SFIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define SFIR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sfir_pkg.sv
// Shared types and constants of the stereo FIR filter.
`default_nettype none

package sfir_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PROD_W     = 2 * SAMPLE_W;
  localparam int unsigned ACC_W      = PROD_W + 4;   // room for 16 products
  localparam int unsigned FRAC_BITS  = 15;           // Q1.15 coefficients
  localparam int unsigned CNT_W      = 5;            // tap and result counts
  localparam int unsigned NUM_COEF   = 16;
  localparam int unsigned COEF_IDX_W = 4;
  localparam int unsigned COEF_WORDS = 4;
  localparam int unsigned COEF_SEL_W = 2;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_ADDR_W = 3;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_TAPS  = 3'd0;
  localparam cfg_addr_t REG_COEF0 = 3'd1;
  localparam cfg_addr_t REG_COEF1 = 3'd2;
  localparam cfg_addr_t REG_COEF2 = 3'd3;
  localparam cfg_addr_t REG_COEF3 = 3'd4;

  localparam logic [CNT_W-1:0] TAPS_RESET = 5'd16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [NUM_COEF-1:0][SAMPLE_W-1:0] coef_bank_t;

  localparam sample_t SAT_MAX = 16'sh7fff;
  localparam sample_t SAT_MIN = 16'sh8000;

endpackage

`default_nettype wire

FILE: rtl/core/sfir_cell.sv
// One tap cell: a stereo window stage, its coefficient and its two products.
`default_nettype none

module sfir_cell
  import sfir_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             load_i,
  input  sample_t          left_i,
  input  sample_t          right_i,
  input  logic [CNT_W-1:0] taps_i,
  input  coef_bank_t       coefs_i,
  output sample_t          left_o,
  output sample_t          right_o,
  output prod_t            left_prod_o,
  output prod_t            right_prod_o
);

  sample_t                left_q, right_q;
  sample_t                coef_q, coef_d;
  prod_t                  left_prod_q, right_prod_q;
  logic [COEF_IDX_W-1:0]  sel;
  logic                   active;

  // window slot Idx meets tap (taps - 1 - Idx); slots past the tap count weigh zero
  assign active = CNT_W'(Idx) < taps_i;
  assign sel    = COEF_IDX_W'(taps_i - CNT_W'(Idx) - CNT_W'(1));
  assign coef_d = active ? $signed(coefs_i[sel]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      coef_q  <= '0;
    end else begin
      coef_q <= coef_d;
      if (shift_i) begin
        left_q  <= left_i;
        right_q <= right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_prod_q  <= left_q * coef_q;
      right_prod_q <= right_q * coef_q;
    end
  end

  assign left_o       = left_q;
  assign right_o      = right_q;
  assign left_prod_o  = left_prod_q;
  assign right_prod_o = right_prod_q;

endmodule

`default_nettype wire

FILE: rtl/core/sfir_reduce.sv
// Registered adder tree, Q1.15 scaling and saturation for one channel.
`default_nettype none

module sfir_reduce
  import sfir_pkg::*;
#(
  parameter int unsigned Taps = 16
) (
  input  logic    clk_i,
  input  logic    load_i,
  input  prod_t   prod_i [Taps],
  output sample_t result_o
);

  localparam int unsigned Groups = (Taps + 3) / 4;
  localparam int unsigned QuoW   = ACC_W - FRAC_BITS;

  acc_t                   part_q [Groups];
  acc_t                   part_d [Groups];
  acc_t                   sum_q, sum_d;
  sample_t                result_q, result_d;
  logic signed [QuoW-1:0] quo;

  // first level: sums of up to four products
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < Taps) begin
          part_d[g] = part_d[g] + ACC_W'(prod_i[g * 4 + k]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < Groups; g++) begin
      sum_d = sum_d + part_q[g];
    end
  end

  // shift right by 15 rounding toward zero, then clamp to 16 bits
  always_comb begin
    quo = $signed(sum_q[ACC_W-1:FRAC_BITS]);
    if (sum_q[ACC_W-1] && (sum_q[FRAC_BITS-1:0] != '0)) begin
      quo = quo + QuoW'(1);
    end
    if (quo > QuoW'(SAT_MAX)) begin
      result_d = SAT_MAX;
    end else if (quo < QuoW'(SAT_MIN)) begin
      result_d = SAT_MIN;
    end else begin
      result_d = $signed(quo[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      part_q   <= part_d;
      sum_q    <= sum_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/stereo_fir_filter_unit.sv
// Stereo forward-looking FIR filter: tap cell chain, reduction trees, output stage.
// Datapath: a filtered pair passes the window, product, group-sum, total and scaling
//   registers, then sits in the output register.
// Throughput: one sample pair per cycle unless the output stalls; a frame end with
//   N tail zeros holds the input for N extra output transfers while the zeros drain.
// Reset: taps_in_use to 16, coefficients and window to zero, no frame open.
`default_nettype none

`include "stereo_fir_filter_unit_assert.svh"

module stereo_fir_filter_unit
  import sfir_pkg::*;
#(
  parameter int unsigned TAPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // left_sample [15:0], right_sample [31:16]
  input  logic                  s_axis_tlast,   // frame_end
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // left_result [15:0], right_result [31:16]
  output logic                  m_axis_tlast,   // last_of_frame
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned Stages = 5;

  // per-item control that rides along with the datapath
  typedef struct packed {
    logic             emit;   // a filtered pair comes out
    logic             last;   // item closed a frame
    logic [CNT_W-1:0] nres;   // total results caused by the item
  } ctl_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]                 taps_q;
  logic [COEF_WORDS-1:0][CFG_W-1:0] coef_q;
  logic [COEF_SEL_W-1:0]            coef_sel;
  coef_bank_t                       coefs;

  assign coef_sel = COEF_SEL_W'(cfg_addr_i - REG_COEF0);
  assign coefs    = coef_bank_t'(coef_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i) inside
        REG_TAPS:               taps_q <= cfg_wdata_i[CNT_W-1:0];
        [REG_COEF0:REG_COEF3]:  coef_q[coef_sel] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // active tap count: zero acts as one, anything above TAPS as TAPS
  logic [CNT_W-1:0] t_act;

  always_comb begin
    if (taps_q == '0) begin
      t_act = CNT_W'(1);
    end else if (taps_q > CNT_W'(TAPS)) begin
      t_act = CNT_W'(TAPS);
    end else begin
      t_act = taps_q;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and frame bookkeeping
  // ---------------------------------------------------------------------
  logic             out_valid_q;
  logic [CNT_W-1:0] rem_q;        // tail zeros still to send
  logic             out_free;
  logic             adv;          // whole pipeline moves one step
  logic             in_fire;

  // the output register can take a new pair; the pipeline stalls while a tail drains
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = out_free && (rem_q == '0);
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && adv;

  logic [CNT_W-1:0] fill_q, fill_next;
  logic [CNT_W-1:0] zeros;
  ctl_t             ctl_in;

  assign fill_next = (fill_q < CNT_W'(TAPS)) ? fill_q + CNT_W'(1) : fill_q;

  always_comb begin
    ctl_in.emit = fill_next >= t_act;
    ctl_in.last = s_axis_tlast;
    zeros       = '0;
    if (s_axis_tlast) begin
      zeros = (fill_next < t_act - CNT_W'(1)) ? fill_next : t_act - CNT_W'(1);
    end
    ctl_in.nres = {{(CNT_W-1){1'b0}}, ctl_in.emit} + zeros;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_fire) begin
      fill_q <= s_axis_tlast ? '0 : fill_next;
    end
  end

  // stage valids and control, aligned with window, products, sums, result
  logic v_q   [Stages];
  ctl_t ctl_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= s_axis_tvalid;
      for (int s = 1; s < Stages; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_in;
      for (int s = 1; s < Stages; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tap cell chain: window slot k holds the sample of k transfers ago
  // ---------------------------------------------------------------------
  sample_t in_left, in_right;
  sample_t win_l  [TAPS];
  sample_t win_r  [TAPS];
  prod_t   prod_l [TAPS];
  prod_t   prod_r [TAPS];

  assign in_left  = $signed(s_axis_tdata[15:0]);
  assign in_right = $signed(s_axis_tdata[31:16]);

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      sfir_cell #(
        .Idx (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (in_fire),
        .load_i       (adv),
        .left_i       (in_left),
        .right_i      (in_right),
        .taps_i       (t_act),
        .coefs_i      (coefs),
        .left_o       (win_l[k]),
        .right_o      (win_r[k]),
        .left_prod_o  (prod_l[k]),
        .right_prod_o (prod_r[k])
      );
    end else begin : g_body
      sfir_cell #(
        .Idx (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (in_fire),
        .load_i       (adv),
        .left_i       (win_l[k-1]),
        .right_i      (win_r[k-1]),
        .taps_i       (t_act),
        .coefs_i      (coefs),
        .left_o       (win_l[k]),
        .right_o      (win_r[k]),
        .left_prod_o  (prod_l[k]),
        .right_prod_o (prod_r[k])
      );
    end
  end

  // ---------------------------------------------------------------------
  // Reduction: three registered steps per channel
  // ---------------------------------------------------------------------
  sample_t res_l, res_r;

  sfir_reduce #(
    .Taps (TAPS)
  ) u_reduce_l (
    .clk_i    (clk_i),
    .load_i   (adv),
    .prod_i   (prod_l),
    .result_o (res_l)
  );

  sfir_reduce #(
    .Taps (TAPS)
  ) u_reduce_r (
    .clk_i    (clk_i),
    .load_i   (adv),
    .prod_i   (prod_r),
    .result_o (res_r)
  );

  // ---------------------------------------------------------------------
  // Output register and tail generator
  // ---------------------------------------------------------------------
  sample_t out_left_q, out_right_q;
  logic    out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_last_q  <= 1'b0;
      rem_q       <= '0;
    end else if (rem_q != '0) begin
      // tail zeros; the final one closes the frame
      if (out_free) begin
        out_valid_q <= 1'b1;
        out_left_q  <= '0;
        out_right_q <= '0;
        out_last_q  <= (rem_q == CNT_W'(1));
        rem_q       <= rem_q - CNT_W'(1);
      end
    end else if (out_free) begin
      if (v_q[Stages-1] && (ctl_q[Stages-1].nres != '0)) begin
        // first result: filtered pair, or a zero if the window never filled
        out_valid_q <= 1'b1;
        out_left_q  <= ctl_q[Stages-1].emit ? res_l : '0;
        out_right_q <= ctl_q[Stages-1].emit ? res_r : '0;
        out_last_q  <= ctl_q[Stages-1].last && (ctl_q[Stages-1].nres == CNT_W'(1));
        rem_q       <= ctl_q[Stages-1].nres - CNT_W'(1);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_right_q, out_left_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SFIR_ASSERT(a_tail_blocks_intake, (rem_q != '0) |-> !s_axis_tready,
               "input taken while a tail is draining")
  `SFIR_ASSERT(a_tail_shown, (rem_q != '0) |-> out_valid_q,
               "tail pending without a result in the output register")
  `SFIR_ASSERT(a_frame_end_result,
               (v_q[Stages-1] && ctl_q[Stages-1].last) |-> (ctl_q[Stages-1].nres != '0),
               "frame end reached the output stage with no result")
  `SFIR_ASSERT_NEXT(a_intake_tracked, s_axis_tvalid && s_axis_tready, v_q[0],
                    "accepted transfer not marked in the window stage")

endmodule

`default_nettype wire
